// ----- hw/rtl/msd_pkg.sv -----
// Shared types and constants for the regularized spectral divide block.
// Used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none
package msd_pkg;

  localparam int unsigned DEN_W  = 81;  // denominator, 24 fraction bits
  localparam int unsigned MAG_W  = 48;  // magnitude of a cross product sum
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned DIM_W  = 10;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned SAMP_W = 24;
  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [2:0] REG_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_DEPTH    = 3'd1;
  localparam logic [2:0] REG_INV_NORM = 3'd2;
  localparam logic [2:0] REG_COEF_X   = 3'd3;
  localparam logic [2:0] REG_COEF_Y   = 3'd4;
  localparam logic [2:0] REG_COEF_Z   = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] depth;
    logic [31:0]      inv_norm;
    logic [31:0]      coef_x;
    logic [31:0]      coef_y;
    logic [31:0]      coef_z;
  } msd_cfg_t;

  // One classified bin handed from the front to the divider.
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [MAG_W-1:0] mag_re;
    logic [MAG_W-1:0] mag_im;
    logic             neg_re;
    logic             neg_im;
    logic             img_zero;
  } msd_item_t;

  // Magnitude of an index after the negative-frequency wrap.
  function automatic logic [DIM_W-1:0] wrap_mag(input logic [IDX_W-1:0] idx,
                                                input logic [DIM_W-1:0] dim);
    logic [DIM_W:0] diff;
    logic [DIM_W:0] mag;
    diff = {2'b00, idx} - {1'b0, dim};
    mag  = diff[DIM_W] ? (~diff + 1'b1) : diff;
    if ({1'b0, idx} <= dim[DIM_W-1:1]) begin
      return {1'b0, idx};
    end
    return mag[DIM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/msd_front.sv -----
// Front pipeline: products, wrapped index squares and the denominator.
// Depends on msd_pkg; feeds msd_queue.
`timescale 1ns / 1ps
`default_nettype none
module msd_front import msd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [IDX_W-1:0]    bin_x,
  input  wire logic [IDX_W-1:0]    bin_y,
  input  wire logic [IDX_W-1:0]    bin_z,
  input  wire logic [SAMP_W-1:0]   img_re,
  input  wire logic [SAMP_W-1:0]   img_im,
  input  wire logic [SAMP_W-1:0]   otf_re,
  input  wire logic [SAMP_W-1:0]   otf_im,
  input  wire msd_cfg_t            cfg,
  output logic                     push,
  output msd_item_t                item
);

  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1
  logic signed [47:0] p_oo_r, p_ii_r, p_rr_r, p_io_r, p_ir_r, p_ro_r;
  logic [17:0] xsq_r;
  logic [19:0] ysq_r, zsq_r;
  logic        zero1_r;
  logic [DIM_W-1:0] ym, zm;

  // Stage 2
  logic [47:0]        osq_r;
  logic signed [48:0] num_re_r, num_im_r;
  logic [49:0]        cx_r;
  logic [51:0]        cy_r, cz_r;
  logic               zero2_r;

  // Stage 3
  logic [55:0]      pl_r, ph_r;
  logic [53:0]      csum_r;
  logic [MAG_W-1:0] mag_re_r, mag_im_r;
  logic             neg_re_r, neg_im_r, zero3_r;
  logic signed [48:0] abs_re, abs_im;

  // Stage 4
  msd_item_t item_r;

  assign ym = wrap_mag(bin_y, cfg.height);
  assign zm = wrap_mag(bin_z, cfg.depth);
  assign abs_re = num_re_r[48] ? -num_re_r : num_re_r;
  assign abs_im = num_im_r[48] ? -num_im_r : num_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_oo_r  <= $signed(otf_re) * $signed(otf_re);
      p_ii_r  <= $signed(otf_im) * $signed(otf_im);
      p_rr_r  <= $signed(img_re) * $signed(otf_re);
      p_io_r  <= $signed(img_im) * $signed(otf_im);
      p_ir_r  <= $signed(img_im) * $signed(otf_re);
      p_ro_r  <= $signed(img_re) * $signed(otf_im);
      xsq_r   <= bin_x * bin_x;
      ysq_r   <= ym * ym;
      zsq_r   <= zm * zm;
      zero1_r <= (img_re == '0) && (img_im == '0);

      osq_r    <= 48'(p_oo_r) + 48'(p_ii_r);
      num_re_r <= 49'(p_rr_r) + 49'(p_io_r);
      num_im_r <= 49'(p_ir_r) - 49'(p_ro_r);
      cx_r     <= cfg.coef_x * xsq_r;
      cy_r     <= cfg.coef_y * ysq_r;
      cz_r     <= cfg.coef_z * zsq_r;
      zero2_r  <= zero1_r;

      // |O|^2 is 48 bits wide, so its product with inv_norm is split in halves.
      pl_r     <= osq_r[23:0] * cfg.inv_norm;
      ph_r     <= osq_r[47:24] * cfg.inv_norm;
      csum_r   <= 54'(cx_r) + 54'(cy_r) + 54'(cz_r);
      mag_re_r <= abs_re[MAG_W-1:0];
      mag_im_r <= abs_im[MAG_W-1:0];
      neg_re_r <= num_re_r[48];
      neg_im_r <= num_im_r[48];
      zero3_r  <= zero2_r;

      item_r.den      <= DEN_W'({ph_r, 24'd0}) + DEN_W'(pl_r) + DEN_W'(csum_r);
      item_r.mag_re   <= mag_re_r;
      item_r.mag_im   <= mag_im_r;
      item_r.neg_re   <= neg_re_r;
      item_r.neg_im   <= neg_im_r;
      item_r.img_zero <= zero3_r;
    end
  end

  assign push = en && v4_r;
  assign item = item_r;

endmodule
`default_nettype wire

// ----- hw/rtl/msd_queue.sv -----
// Short queue between the front pipeline and the divider pipeline.
// Depends on msd_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module msd_queue import msd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire msd_item_t  push_item,
  input  wire logic       pop,
  output msd_item_t       head,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  msd_item_t        mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/msd_back.sv -----
// Divider pipeline: one restoring step per stage for both quotients,
// then sign, saturation and special cases into the output register.
// Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msd_back import msd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         avail,
  input  wire msd_item_t    head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [QUO_W-1:0]  out_re,
  output logic [QUO_W-1:0]  out_im,
  output logic              out_zd
);

  localparam int unsigned NS = QUO_W + 1;

  logic             v_r    [NS];
  logic [DEN_W-1:0] den_r  [NS];
  logic [DEN_W-1:0] rre_r  [NS];
  logic [DEN_W-1:0] rim_r  [NS];
  logic [QUO_W-1:0] qre_r  [NS];
  logic [QUO_W-1:0] qim_r  [NS];
  logic [5:0]       flg_r  [NS];  // img_zero, den_zero, neg_re, neg_im, sat_re, sat_im

  logic             ov_r;
  logic [QUO_W-1:0] ore_r, oim_r;
  logic             ozd_r;
  logic             en;

  logic [DEN_W-1:0] sh_re, sh_im;

  assign en  = !ov_r || out_ready;
  assign pop = en && avail;

  assign sh_re = DEN_W'({head.mag_re, 8'd0});
  assign sh_im = DEN_W'({head.mag_im, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        v_r[i] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= avail;
      for (int i = 1; i < NS; i++) begin
        v_r[i] <= v_r[i-1];
      end
      ov_r <= v_r[NS-1];
    end
  end

  // The numerator carries no set bits below 2^8, so after the saturation
  // test the remaining 32 steps shift in zeros.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= head.den;
      rre_r[0] <= sh_re;
      rim_r[0] <= sh_im;
      qre_r[0] <= '0;
      qim_r[0] <= '0;
      flg_r[0] <= {head.img_zero, head.den == '0, head.neg_re, head.neg_im,
                   sh_re >= head.den, sh_im >= head.den};
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [DEN_W:0] tre, tim;
    logic           gre, gim;
    assign tre = {rre_r[k-1], 1'b0};
    assign tim = {rim_r[k-1], 1'b0};
    assign gre = tre >= {1'b0, den_r[k-1]};
    assign gim = tim >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
        flg_r[k] <= flg_r[k-1];
        rre_r[k] <= gre ? DEN_W'(tre - {1'b0, den_r[k-1]}) : DEN_W'(tre);
        rim_r[k] <= gim ? DEN_W'(tim - {1'b0, den_r[k-1]}) : DEN_W'(tim);
        qre_r[k] <= {qre_r[k-1][QUO_W-2:0], gre};
        qim_r[k] <= {qim_r[k-1][QUO_W-2:0], gim};
      end
    end
  end

  function automatic logic [QUO_W-1:0] finish(input logic [QUO_W-1:0] q,
                                              input logic neg, input logic sat);
    if (neg) begin
      if (sat || (q > {1'b1, {(QUO_W-1){1'b0}}})) begin
        return {1'b1, {(QUO_W-1){1'b0}}};
      end
      return ~q + 1'b1;
    end
    if (sat || q[QUO_W-1]) begin
      return {1'b0, {(QUO_W-1){1'b1}}};
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_r[NS-1][5] || flg_r[NS-1][4]) begin
        ore_r <= '0;
        oim_r <= '0;
        ozd_r <= !flg_r[NS-1][5];
      end else begin
        ore_r <= finish(qre_r[NS-1], flg_r[NS-1][3], flg_r[NS-1][1]);
        oim_r <= finish(qim_r[NS-1], flg_r[NS-1][2], flg_r[NS-1][0]);
        ozd_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_re    = ore_r;
  assign out_im    = oim_r;
  assign out_zd    = ozd_r;

endmodule
`default_nettype wire

// ----- hw/rtl/map_regularized_spectral_divide_top.sv -----
// Regularized spectral divide of one 3-D half-spectrum bin per transfer.
// Path: 4 front stages, the queue, 33 divider stages and 1 output register.
// Throughput: one bin per cycle while out_tready does not stall the output;
// the 32-stage restoring divider sets the depth.
// Reset (synchronous, rst_n low) empties all pipelines and restores registers.
`timescale 1ns / 1ps
`default_nettype none
module map_regularized_spectral_divide_top import msd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // bin_x, bin_y, bin_z, img_re, img_im, otf_re, otf_im, zero pad
  input  wire logic [127:0]          in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_re, out_im
  output logic [63:0]                out_tdata,
  // zero_denominator
  output logic                       out_tuser,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  msd_cfg_t  cfg_r;
  msd_item_t f_item, q_head;
  logic      f_push, q_full, q_empty, b_pop;
  logic      wr;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height   <= DIM_W'(1);
      cfg_r.depth    <= DIM_W'(1);
      cfg_r.inv_norm <= 32'h0100_0000;
      cfg_r.coef_x   <= '0;
      cfg_r.coef_y   <= '0;
      cfg_r.coef_z   <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_HEIGHT:   cfg_r.height   <= cfg_pwdata[DIM_W-1:0];
        REG_DEPTH:    cfg_r.depth    <= cfg_pwdata[DIM_W-1:0];
        REG_INV_NORM: cfg_r.inv_norm <= cfg_pwdata;
        REG_COEF_X:   cfg_r.coef_x   <= cfg_pwdata;
        REG_COEF_Y:   cfg_r.coef_y   <= cfg_pwdata;
        REG_COEF_Z:   cfg_r.coef_z   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_HEIGHT:   cfg_prdata = 32'(cfg_r.height);
      REG_DEPTH:    cfg_prdata = 32'(cfg_r.depth);
      REG_INV_NORM: cfg_prdata = cfg_r.inv_norm;
      REG_COEF_X:   cfg_prdata = cfg_r.coef_x;
      REG_COEF_Y:   cfg_prdata = cfg_r.coef_y;
      REG_COEF_Z:   cfg_prdata = cfg_r.coef_z;
      default:      cfg_prdata = '0;
    endcase
  end

  // The front advances whenever the queue has room.
  assign in_tready = !q_full;

  msd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (!q_full),
    .in_valid (in_tvalid),
    .bin_x    (in_tdata[8:0]),
    .bin_y    (in_tdata[17:9]),
    .bin_z    (in_tdata[26:18]),
    .img_re   (in_tdata[50:27]),
    .img_im   (in_tdata[74:51]),
    .otf_re   (in_tdata[98:75]),
    .otf_im   (in_tdata[122:99]),
    .cfg      (cfg_r),
    .push     (f_push),
    .item     (f_item)
  );

  msd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (b_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  msd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (!q_empty),
    .head      (q_head),
    .pop       (b_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_re    (out_tdata[31:0]),
    .out_im    (out_tdata[63:32]),
    .out_zd    (out_tuser)
  );

endmodule
`default_nettype wire
